@@ rtl/core/assert_macros.svh @@
// Assertion macros for the port-level checker of the edge counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SETC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("setc check failed: same-cycle property");

// Next-cycle implication, disabled while reset is asserted.
`define SETC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("setc check failed: next-cycle property");

`endif

@@ rtl/core/setc_pkg.sv @@
// Shared constants, types and codes of the Sobel edge threshold counter.
package setc_pkg;

    // Frame geometry.
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 12;
    localparam int ROW_W     = 12;
    localparam int CW        = ((COL_W > WID_W) ? COL_W : WID_W) + 1;
    localparam int RW        = ROW_W + 1;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int THR_W      = 11;
    localparam int FAC_W      = 16;
    localparam int CNT_W      = 24;
    localparam int DENS_W     = 17;
    localparam int CONF_W     = 7;
    localparam int DENS_FRAC  = 16;
    localparam int SUM_W      = PIX_W + 2;
    localparam int MAG_W      = PIX_W + 3;

    // Frame summary arithmetic.
    localparam int INT_W      = CW + ROW_W;
    localparam int PROD_W     = CNT_W + FAC_W;
    localparam int SCL_W      = PROD_W + 7;
    localparam int CONFN_W    = SCL_W - 8;
    localparam int DIVD_W     = CNT_W + DENS_FRAC;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_MAP  = 3'd4;

    // Register reset values.
    localparam logic [THR_W-1:0] THRESHOLD_RST = 11'd100;
    localparam logic [FAC_W-1:0] FACTOR_RST    = 16'd256;
    localparam logic [WID_W-1:0] WIDTH_RST     = 12'd320;
    localparam logic [ROW_W-1:0] HEIGHT_RST    = 12'd240;

    // Result codes and limits.
    localparam logic KIND_MAP = 1'b0;
    localparam logic KIND_SUM = 1'b1;

    localparam logic DIV_DENS = 1'b0;
    localparam logic DIV_CONF = 1'b1;

    localparam logic [PIX_W-1:0]  EDGE_VAL  = 8'd255;
    localparam logic [PIX_W-1:0]  FLAT_VAL  = 8'd0;
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [DENS_W-1:0] DENS_MAX  = 17'h10000;
    localparam logic [CONF_W-1:0] CONF_MAX  = 7'd100;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic pix_take;
        logic shift;
        logic eval;
        logic load_map;
        logic calc_int;
        logic calc_prod;
        logic calc_scale;
        logic div_start;
        logic div_sel;
        logic store_dens;
        logic store_conf;
        logic load_sum;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic map_due;
        logic frame_end;
        logic out_free;
        logic div_done;
        logic interior_zero;
    } dp_sts_t;

endpackage

@@ rtl/core/setc_if.sv @@
// Channel interfaces: pixel input, result output and configuration write.
interface setc_pix_if;
    logic                        valid;
    logic                        ready;
    logic [setc_pkg::PIX_W-1:0]  pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface setc_res_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [setc_pkg::PIX_W-1:0]  map_value;
    logic [setc_pkg::COL_W-1:0]  map_x;
    logic [setc_pkg::ROW_W-1:0]  map_y;
    logic [setc_pkg::CNT_W-1:0]  edge_count;
    logic [setc_pkg::DENS_W-1:0] density_q16;
    logic [setc_pkg::CONF_W-1:0] confidence;
    logic                        last;

    modport source (output valid, output kind, output map_value, output map_x,
                    output map_y, output edge_count, output density_q16,
                    output confidence, output last, input ready);
    modport sink   (input valid, input kind, input map_value, input map_x,
                    input map_y, input edge_count, input density_q16,
                    input confidence, input last, output ready);
endinterface

interface setc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [setc_pkg::CFG_IDX_W-1:0]   index;
    logic [setc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/setc_ram.sv @@
// Generic single-port-write, registered-read RAM.
module setc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/setc_div.sv @@
// Restoring divider that retires one quotient bit per cycle.
module setc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [setc_pkg::DIVD_W-1:0]   dividend,
    input  logic [setc_pkg::INT_W-1:0]    divisor,
    output logic [setc_pkg::DIVD_W-1:0]   quotient,
    output logic                          done
);

    localparam int STEP_W = $clog2(setc_pkg::DIVD_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [setc_pkg::INT_W-1:0]    rem_reg;
    logic [setc_pkg::INT_W-1:0]    dsr_reg;
    logic [setc_pkg::DIVD_W-1:0]   quo_reg;

    logic [setc_pkg::INT_W:0]      shifted;
    logic [setc_pkg::INT_W:0]      diff;
    logic                          fits;
    logic [setc_pkg::INT_W-1:0]    rem_next;

    // One trial subtraction of the shifted partial remainder.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[setc_pkg::DIVD_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        fits     = (shifted >= {1'b0, dsr_reg});
        rem_next = fits ? diff[setc_pkg::INT_W-1:0] : shifted[setc_pkg::INT_W-1:0];
    end

    // Control: step count, busy and a one-cycle done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(setc_pkg::DIVD_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[setc_pkg::DIVD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ rtl/core/setc_dp.sv @@
// Datapath: configuration, line stores, 3x3 window, Sobel magnitude, summary math.
module setc_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  setc_pkg::dp_cmd_t                 cmd,
    output setc_pkg::dp_sts_t                 sts,
    input  logic [setc_pkg::PIX_W-1:0]        pixel,
    input  logic                              cfg_we,
    input  logic [setc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [setc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              res_ready,
    output logic                              res_valid,
    output logic                              res_kind,
    output logic [setc_pkg::PIX_W-1:0]        res_map_value,
    output logic [setc_pkg::COL_W-1:0]        res_map_x,
    output logic [setc_pkg::ROW_W-1:0]        res_map_y,
    output logic [setc_pkg::CNT_W-1:0]        res_edge_count,
    output logic [setc_pkg::DENS_W-1:0]       res_density_q16,
    output logic [setc_pkg::CONF_W-1:0]       res_confidence,
    output logic                              res_last
);

    // Configuration registers.
    logic [setc_pkg::THR_W-1:0]   thr_reg;
    logic [setc_pkg::FAC_W-1:0]   fac_reg;
    logic [setc_pkg::WID_W-1:0]   wid_reg;
    logic [setc_pkg::ROW_W-1:0]   hgt_reg;
    logic                         emit_reg;

    // Pixel stream state.
    logic [setc_pkg::PIX_W-1:0]   pix_reg;
    logic [setc_pkg::PIX_W-1:0]   win_reg [0:8];
    logic [setc_pkg::COL_W-1:0]   col_reg;
    logic [setc_pkg::ROW_W-1:0]   row_reg;
    logic [setc_pkg::CNT_W-1:0]   total_reg;
    logic                         map_due_reg;
    logic                         frame_end_reg;
    logic                         edge_reg;
    logic [setc_pkg::COL_W-1:0]   map_x_reg;
    logic [setc_pkg::ROW_W-1:0]   map_y_reg;

    // Frame summary state.
    logic [setc_pkg::CNT_W-1:0]   sum_count_reg;
    logic [setc_pkg::INT_W-1:0]   interior_reg;
    logic [setc_pkg::PROD_W-1:0]  prod_reg;
    logic [setc_pkg::CONFN_W-1:0] conf_num_reg;
    logic [setc_pkg::DENS_W-1:0]  dens_reg;
    logic [setc_pkg::CONF_W-1:0]  conf_reg;

    // Output register.
    logic                         valid_reg;
    logic                         kind_reg;
    logic [setc_pkg::PIX_W-1:0]   value_reg;
    logic [setc_pkg::COL_W-1:0]   ox_reg;
    logic [setc_pkg::ROW_W-1:0]   oy_reg;
    logic [setc_pkg::CNT_W-1:0]   ocnt_reg;
    logic [setc_pkg::DENS_W-1:0]  odens_reg;
    logic [setc_pkg::CONF_W-1:0]  oconf_reg;
    logic                         olast_reg;

    // Line store ports.
    logic [setc_pkg::PIX_W-1:0]   row_a_data;
    logic [setc_pkg::PIX_W-1:0]   row_b_data;

    // Combinational values.
    logic [setc_pkg::CW-1:0]      w_eff;
    logic [setc_pkg::ROW_W-1:0]   h_eff;
    logic [setc_pkg::CW-1:0]      col_inc;
    logic [setc_pkg::RW-1:0]      row_inc;
    logic [setc_pkg::SUM_W-1:0]   gx_pos;
    logic [setc_pkg::SUM_W-1:0]   gx_neg;
    logic [setc_pkg::SUM_W-1:0]   gy_pos;
    logic [setc_pkg::SUM_W-1:0]   gy_neg;
    logic [setc_pkg::SUM_W-1:0]   gx_abs;
    logic [setc_pkg::SUM_W-1:0]   gy_abs;
    logic [setc_pkg::MAG_W-1:0]   mag;
    logic                         is_edge;
    logic                         in_interior;
    logic                         row_end;
    logic                         frame_end;
    logic [setc_pkg::CNT_W-1:0]   total_next;
    logic [setc_pkg::SCL_W-1:0]   prod_ext;
    logic [setc_pkg::SCL_W-1:0]   scaled;
    logic [setc_pkg::DIVD_W-1:0]  div_dividend;
    logic [setc_pkg::DIVD_W-1:0]  div_quotient;
    logic                         div_done;
    logic                         out_free;

    // Configuration writes; indexes past the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= setc_pkg::THRESHOLD_RST;
            fac_reg  <= setc_pkg::FACTOR_RST;
            wid_reg  <= setc_pkg::WIDTH_RST;
            hgt_reg  <= setc_pkg::HEIGHT_RST;
            emit_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                setc_pkg::REG_THRESHOLD: thr_reg  <= cfg_data[setc_pkg::THR_W-1:0];
                setc_pkg::REG_FACTOR:    fac_reg  <= cfg_data[setc_pkg::FAC_W-1:0];
                setc_pkg::REG_WIDTH:     wid_reg  <= cfg_data[setc_pkg::WID_W-1:0];
                setc_pkg::REG_HEIGHT:    hgt_reg  <= cfg_data[setc_pkg::ROW_W-1:0];
                setc_pkg::REG_EMIT_MAP:  emit_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective frame size: zero acts as one, width is capped at the line store depth.
    always_comb
    begin
        if (wid_reg == '0)
        begin
            w_eff = setc_pkg::CW'(1);
        end
        else if (setc_pkg::CW'(wid_reg) > setc_pkg::CW'(setc_pkg::MAX_WIDTH))
        begin
            w_eff = setc_pkg::CW'(setc_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = setc_pkg::CW'(wid_reg);
        end
        h_eff = (hgt_reg == '0) ? setc_pkg::ROW_W'(1) : hgt_reg;
    end

    // Line stores: row above and two rows above, read at the accepted column.
    setc_ram #(
        .WIDTH (setc_pkg::PIX_W),
        .DEPTH (setc_pkg::MAX_WIDTH)
    ) u_row_a (
        .clk     (clk),
        .wr_en   (cmd.shift),
        .wr_addr (col_reg),
        .wr_data (pix_reg),
        .rd_en   (cmd.pix_take),
        .rd_addr (col_reg),
        .rd_data (row_a_data)
    );

    setc_ram #(
        .WIDTH (setc_pkg::PIX_W),
        .DEPTH (setc_pkg::MAX_WIDTH)
    ) u_row_b (
        .clk     (clk),
        .wr_en   (cmd.shift),
        .wr_addr (col_reg),
        .wr_data (row_a_data),
        .rd_en   (cmd.pix_take),
        .rd_addr (col_reg),
        .rd_data (row_b_data)
    );

    // Sobel gradients as positive and negative halves, then L1 magnitude.
    always_comb
    begin
        gx_pos = setc_pkg::SUM_W'(win_reg[2]) + {1'b0, win_reg[5], 1'b0}
               + setc_pkg::SUM_W'(win_reg[8]);
        gx_neg = setc_pkg::SUM_W'(win_reg[0]) + {1'b0, win_reg[3], 1'b0}
               + setc_pkg::SUM_W'(win_reg[6]);
        gy_pos = setc_pkg::SUM_W'(win_reg[6]) + {1'b0, win_reg[7], 1'b0}
               + setc_pkg::SUM_W'(win_reg[8]);
        gy_neg = setc_pkg::SUM_W'(win_reg[0]) + {1'b0, win_reg[1], 1'b0}
               + setc_pkg::SUM_W'(win_reg[2]);
        gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
        gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
        mag    = setc_pkg::MAG_W'(gx_abs) + setc_pkg::MAG_W'(gy_abs);
        is_edge = (mag > setc_pkg::MAG_W'(thr_reg));
    end

    // Position tests for the pixel that just filled the window.
    always_comb
    begin
        col_inc   = setc_pkg::CW'(col_reg) + 1'b1;
        row_inc   = setc_pkg::RW'(row_reg) + 1'b1;
        in_interior = (col_reg >= setc_pkg::COL_W'(2)) && (row_reg >= setc_pkg::ROW_W'(2))
                   && (col_inc <= w_eff) && (row_inc <= setc_pkg::RW'(h_eff));
        row_end   = (col_inc >= w_eff);
        frame_end = row_end && (row_inc >= setc_pkg::RW'(h_eff));
        total_next = (in_interior && is_edge && (total_reg != setc_pkg::CNT_MAX))
                   ? total_reg + 1'b1 : total_reg;
    end

    // Window, position and edge count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            col_reg       <= '0;
            row_reg       <= '0;
            total_reg     <= '0;
            map_due_reg   <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            if (cmd.shift)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2] <= row_b_data;
                win_reg[5] <= row_a_data;
                win_reg[8] <= pix_reg;
            end
            if (cmd.eval)
            begin
                map_due_reg   <= in_interior && emit_reg;
                frame_end_reg <= frame_end;
                total_reg     <= frame_end ? '0 : total_next;
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= frame_end ? '0 : row_inc[setc_pkg::ROW_W-1:0];
                end
                else
                begin
                    col_reg <= col_inc[setc_pkg::COL_W-1:0];
                end
            end
        end
    end

    // Pixel capture and per-pixel result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.pix_take)
        begin
            pix_reg <= pixel;
        end
        if (cmd.eval)
        begin
            edge_reg  <= is_edge;
            map_x_reg <= col_reg - 1'b1;
            map_y_reg <= row_reg - 1'b1;
            if (frame_end)
            begin
                sum_count_reg <= total_next;
            end
        end
    end

    // Summary arithmetic: interior area, count times factor, times 100 over 256.
    assign prod_ext = setc_pkg::SCL_W'(prod_reg);
    assign scaled   = (prod_ext << 6) + (prod_ext << 5) + (prod_ext << 2);

    always_ff @(posedge clk)
    begin
        if (cmd.calc_int)
        begin
            if ((w_eff >= setc_pkg::CW'(3)) && (h_eff >= setc_pkg::ROW_W'(3)))
            begin
                interior_reg <= setc_pkg::INT_W'(w_eff - setc_pkg::CW'(2))
                                * setc_pkg::INT_W'(h_eff - setc_pkg::ROW_W'(2));
            end
            else
            begin
                interior_reg <= '0;
            end
            dens_reg <= '0;
            conf_reg <= '0;
        end
        if (cmd.calc_prod)
        begin
            prod_reg <= setc_pkg::PROD_W'(sum_count_reg) * setc_pkg::PROD_W'(fac_reg);
        end
        if (cmd.calc_scale)
        begin
            conf_num_reg <= scaled[setc_pkg::SCL_W-1:8];
        end
        if (cmd.store_dens)
        begin
            dens_reg <= (div_quotient > setc_pkg::DIVD_W'(setc_pkg::DENS_MAX))
                      ? setc_pkg::DENS_MAX : div_quotient[setc_pkg::DENS_W-1:0];
        end
        if (cmd.store_conf)
        begin
            conf_reg <= (div_quotient > setc_pkg::DIVD_W'(setc_pkg::CONF_MAX))
                      ? setc_pkg::CONF_MAX : div_quotient[setc_pkg::CONF_W-1:0];
        end
    end

    // Shared serial divider for density and confidence.
    assign div_dividend = (cmd.div_sel == setc_pkg::DIV_CONF)
                        ? setc_pkg::DIVD_W'(conf_num_reg)
                        : {sum_count_reg, {setc_pkg::DENS_FRAC{1'b0}}};

    setc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (interior_reg),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // Output register: one result slot that frees when the sink takes it.
    assign out_free = !valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.load_map || cmd.load_sum)
        begin
            valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_map)
        begin
            kind_reg  <= setc_pkg::KIND_MAP;
            value_reg <= edge_reg ? setc_pkg::EDGE_VAL : setc_pkg::FLAT_VAL;
            ox_reg    <= map_x_reg;
            oy_reg    <= map_y_reg;
            ocnt_reg  <= '0;
            odens_reg <= '0;
            oconf_reg <= '0;
            olast_reg <= 1'b0;
        end
        else if (cmd.load_sum)
        begin
            kind_reg  <= setc_pkg::KIND_SUM;
            value_reg <= setc_pkg::FLAT_VAL;
            ox_reg    <= '0;
            oy_reg    <= '0;
            ocnt_reg  <= sum_count_reg;
            odens_reg <= dens_reg;
            oconf_reg <= conf_reg;
            olast_reg <= 1'b1;
        end
    end

    assign res_valid       = valid_reg;
    assign res_kind        = kind_reg;
    assign res_map_value   = value_reg;
    assign res_map_x       = ox_reg;
    assign res_map_y       = oy_reg;
    assign res_edge_count  = ocnt_reg;
    assign res_density_q16 = odens_reg;
    assign res_confidence  = oconf_reg;
    assign res_last        = olast_reg;

    // Status toward the controller.
    always_comb
    begin
        sts.map_due       = map_due_reg;
        sts.frame_end     = frame_end_reg;
        sts.out_free      = out_free;
        sts.div_done      = div_done;
        sts.interior_zero = (interior_reg == '0);
    end

endmodule

@@ rtl/core/setc_ctrl.sv @@
// Controller: sequences pixel processing, map output and the frame summary.
module setc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  setc_pkg::dp_sts_t  sts,
    output setc_pkg::dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_CALC  = 4'd2;
    localparam logic [3:0] S_MAP   = 4'd3;
    localparam logic [3:0] S_INT   = 4'd4;
    localparam logic [3:0] S_PROD  = 4'd5;
    localparam logic [3:0] S_SCALE = 4'd6;
    localparam logic [3:0] S_DIVD  = 4'd7;
    localparam logic [3:0] S_DIVC  = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        pix_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                pix_ready = 1'b1;
                if (pix_valid)
                begin
                    cmd.pix_take = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                cmd.shift  = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.eval   = 1'b1;
                state_next = S_MAP;
            end
            S_MAP:
            begin
                if (!sts.map_due || sts.out_free)
                begin
                    cmd.load_map = sts.map_due;
                    state_next   = sts.frame_end ? S_INT : S_IDLE;
                end
            end
            S_INT:
            begin
                cmd.calc_int = 1'b1;
                state_next   = S_PROD;
            end
            S_PROD:
            begin
                cmd.calc_prod = 1'b1;
                state_next    = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.calc_scale = 1'b1;
                if (sts.interior_zero)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = setc_pkg::DIV_DENS;
                    state_next    = S_DIVD;
                end
            end
            S_DIVD:
            begin
                cmd.div_sel = setc_pkg::DIV_CONF;
                if (sts.div_done)
                begin
                    cmd.store_dens = 1'b1;
                    cmd.div_start  = 1'b1;
                    state_next     = S_DIVC;
                end
            end
            S_DIVC:
            begin
                if (sts.div_done)
                begin
                    cmd.store_conf = 1'b1;
                    state_next     = S_SUM;
                end
            end
            S_SUM:
            begin
                if (sts.out_free)
                begin
                    cmd.load_sum = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/sobel_edge_threshold_counter_unit.sv @@
// Map result: after a pixel's transaction the controller runs its read, window and
// evaluate steps around the registered line store read, then loads the output slot.
// A new pixel is taken only after the last is through; output stalls hold it back.
// Frame end: the summary follows the last pixel after the area and scaling steps and
// two passes of the bit-serial divider, which are skipped when the interior is empty.
// Reset: position, window, edge count and configuration return to their defaults.
module sobel_edge_threshold_counter_unit (
    input  logic         clk,
    input  logic         rst_n,
    setc_pix_if.sink     pix,
    setc_res_if.source   res,
    setc_cfg_if.sink     cfg
);

    setc_pkg::dp_cmd_t cmd;
    setc_pkg::dp_sts_t sts;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    setc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix.valid),
        .pix_ready (pix.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    setc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .pixel           (pix.pixel),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .res_ready       (res.ready),
        .res_valid       (res.valid),
        .res_kind        (res.kind),
        .res_map_value   (res.map_value),
        .res_map_x       (res.map_x),
        .res_map_y       (res.map_y),
        .res_edge_count  (res.edge_count),
        .res_density_q16 (res.density_q16),
        .res_confidence  (res.confidence),
        .res_last        (res.last)
    );

endmodule

@@ rtl/core/setc_chk.sv @@
// Port-level checker for the edge counter, bound to the top level.
`include "assert_macros.svh"

module setc_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         pix_valid,
    input logic                         pix_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         res_kind,
    input logic [setc_pkg::PIX_W-1:0]   res_map_value,
    input logic [setc_pkg::CNT_W-1:0]   res_edge_count,
    input logic [setc_pkg::DENS_W-1:0]  res_density_q16,
    input logic [setc_pkg::CONF_W-1:0]  res_confidence,
    input logic                         res_last
);

    // After a pixel transaction, ready is dropped while the block is busy with that pixel.
    `SETC_ASSERT_NEXT(a_pix_busy, clk, rst_n, pix_valid && pix_ready, !pix_ready)

    // A frame summary is marked last and stays within its saturation limits.
    `SETC_ASSERT_NOW(a_sum_limits, clk, rst_n, res_valid && (res_kind == setc_pkg::KIND_SUM), res_last && (res_confidence <= setc_pkg::CONF_MAX) && (res_density_q16 <= setc_pkg::DENS_MAX))

    // A stalled result stays offered.
    `SETC_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)

    // A stalled result keeps its kind, map value, count, density and confidence.
    `SETC_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(res_kind) && $stable(res_map_value) && $stable(res_edge_count) && $stable(res_density_q16) && $stable(res_confidence))

endmodule

bind sobel_edge_threshold_counter_unit setc_chk u_setc_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .pix_valid       (pix.valid),
    .pix_ready       (pix.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_kind        (res.kind),
    .res_map_value   (res.map_value),
    .res_edge_count  (res.edge_count),
    .res_density_q16 (res.density_q16),
    .res_confidence  (res.confidence),
    .res_last        (res.last)
);

@@ verif/tb_sobel_edge_threshold_counter_unit.sv @@
// Self-checking testbench for the Sobel edge threshold counter: directed frames, extremes, random.
module tb_sobel_edge_threshold_counter_unit;

    localparam int      CLK_PERIOD     = 20;
    localparam longint  TIMEOUT_CYCLES = 4_000_000;
    localparam int      RESET_CYCLES   = 9;
    localparam int      SETTLE_CYCLES  = 16;
    localparam int      HOLD_CYCLES    = 300;
    localparam int      RANDOM_ITEMS   = 220;
    localparam int      HEAVY_IDLE_PCT = 63;
    localparam int      LIGHT_IDLE_PCT = 10;
    localparam int      MAX_REPORTS    = 10;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {PAT_NOISE, PAT_FLAT, PAT_VSTEP, PAT_HSTEP, PAT_DIAG, PAT_CHECKER}
        pixel_pattern_t;

    // One result of the block, with fields in port order.
    typedef struct packed {
        logic                          kind;
        logic [setc_pkg::PIX_W-1:0]    map_value;
        logic [setc_pkg::COL_W-1:0]    map_x;
        logic [setc_pkg::ROW_W-1:0]    map_y;
        logic [setc_pkg::CNT_W-1:0]    edge_count;
        logic [setc_pkg::DENS_W-1:0]   density_q16;
        logic [setc_pkg::CONF_W-1:0]   confidence;
        logic                          last;
    } edge_result_t;

    logic clk;
    logic rst_n;

    setc_pix_if pix ();
    setc_res_if res ();
    setc_cfg_if cfg ();

    sobel_edge_threshold_counter_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .res   (res),
        .cfg   (cfg)
    );

    // Shadow copy of the configuration registers.
    logic [setc_pkg::THR_W-1:0] thr_reg;
    logic [setc_pkg::FAC_W-1:0] factor_reg;
    logic [setc_pkg::WID_W-1:0] width_reg;
    logic [setc_pkg::ROW_W-1:0] height_reg;
    logic                       emit_map_reg;

    // Sobel state mirrored from the block.
    logic [setc_pkg::PIX_W-1:0] row_above     [setc_pkg::MAX_WIDTH];
    logic [setc_pkg::PIX_W-1:0] row_two_above [setc_pkg::MAX_WIDTH];
    logic [setc_pkg::PIX_W-1:0] window3x3     [3][3];
    int                         col_pos;
    int                         row_pos;
    logic [setc_pkg::CNT_W-1:0] edge_tally;

    edge_result_t outputs_due [$];

    // Run statistics and failure bookkeeping.
    int error_count;
    int pixels_total;
    int frames_total;
    int maps_checked;
    int summaries_checked;

    // Idling controls and the long receiver hold.
    int   sender_idle_pct;
    int   receiver_stall_pct;
    logic receiver_held;
    event receiver_hold;

    // Per-frame pattern parameters.
    int frame_lo;
    int frame_hi;
    int frame_split;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("status: fail");
        $finish;
    end

    function automatic int effective_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > setc_pkg::MAX_WIDTH)
            return setc_pkg::MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int effective_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function automatic string describe(edge_result_t r);
        return $sformatf("kind=%0d value=%0d x=%0d y=%0d count=%0d dens=%0d conf=%0d last=%0d",
                         r.kind, r.map_value, r.map_x, r.map_y, r.edge_count,
                         r.density_q16, r.confidence, r.last);
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Advance the Sobel state by one pixel and queue the results it causes.
    task automatic sobel_step(input logic [setc_pkg::PIX_W-1:0] p);
        int           w;
        int           h;
        int           k;
        int           gx;
        int           gy;
        int           mag;
        bit           is_edge;
        longint       interior;
        longint       cnt;
        longint       dens;
        longint       conf;
        edge_result_t r;

        w = effective_width();
        h = effective_height();

        // Shift the window left and load the new column.
        for (k = 0; k < 3; k++)
        begin
            window3x3[k][0] = window3x3[k][1];
            window3x3[k][1] = window3x3[k][2];
        end
        window3x3[0][2] = row_two_above[col_pos];
        window3x3[1][2] = row_above[col_pos];
        window3x3[2][2] = p;
        row_two_above[col_pos] = row_above[col_pos];
        row_above[col_pos] = p;

        // Evaluate the interior pixel centered in the window.
        if (col_pos >= 2 && row_pos >= 2 && col_pos + 1 <= w && row_pos + 1 <= h)
        begin
            gx = (int'(window3x3[0][2]) + 2 * int'(window3x3[1][2]) + int'(window3x3[2][2]))
               - (int'(window3x3[0][0]) + 2 * int'(window3x3[1][0]) + int'(window3x3[2][0]));
            gy = (int'(window3x3[2][0]) + 2 * int'(window3x3[2][1]) + int'(window3x3[2][2]))
               - (int'(window3x3[0][0]) + 2 * int'(window3x3[0][1]) + int'(window3x3[0][2]));
            mag = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
            is_edge = mag > int'(thr_reg);
            if (is_edge && edge_tally != setc_pkg::CNT_MAX)
                edge_tally++;
            if (emit_map_reg)
            begin
                r = '0;
                r.kind = setc_pkg::KIND_MAP;
                r.map_value = is_edge ? setc_pkg::EDGE_VAL : setc_pkg::FLAT_VAL;
                r.map_x = setc_pkg::COL_W'(col_pos - 1);
                r.map_y = setc_pkg::ROW_W'(row_pos - 1);
                outputs_due.push_back(r);
            end
        end

        // Advance the raster position; the last pixel of a frame adds the summary.
        if (col_pos + 1 >= w)
        begin
            if (row_pos + 1 >= h)
            begin
                interior = (w >= 3 && h >= 3) ? longint'(w - 2) * longint'(h - 2) : 0;
                cnt = longint'(edge_tally);
                dens = 0;
                conf = 0;
                if (interior != 0)
                begin
                    dens = (cnt << setc_pkg::DENS_FRAC) / interior;
                    if (dens > longint'(setc_pkg::DENS_MAX))
                        dens = longint'(setc_pkg::DENS_MAX);
                    conf = (cnt * longint'(factor_reg) * 100) / (interior * 256);
                    if (conf > longint'(setc_pkg::CONF_MAX))
                        conf = longint'(setc_pkg::CONF_MAX);
                end
                r = '0;
                r.kind = setc_pkg::KIND_SUM;
                r.edge_count = edge_tally;
                r.density_q16 = setc_pkg::DENS_W'(dens);
                r.confidence = setc_pkg::CONF_W'(conf);
                r.last = 1'b1;
                outputs_due.push_back(r);
                col_pos = 0;
                row_pos = 0;
                edge_tally = '0;
            end
            else
            begin
                col_pos = 0;
                row_pos = row_pos + 1;
            end
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endtask

    // Compare one accepted result with the oldest expectation.
    task automatic check_result();
        edge_result_t got;
        edge_result_t want;

        got = '{res.kind, res.map_value, res.map_x, res.map_y, res.edge_count,
                res.density_q16, res.confidence, res.last};
        if (outputs_due.size() == 0)
        begin
            note_failure($sformatf("result with nothing expected: %s", describe(got)));
        end
        else
        begin
            want = outputs_due.pop_front();
            if (got !== want)
                note_failure($sformatf("mismatch: expected %s | got %s",
                                       describe(want), describe(got)));
            if (want.kind == setc_pkg::KIND_SUM)
                summaries_checked++;
            else
                maps_checked++;
        end
    endtask

    // Result side: check each transaction and drive ready with random stalls.
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res.valid === 1'b1 && res.ready === 1'b1)
                check_result();
            res.ready <= !receiver_held && ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Long receiver hold, counted in cycles once triggered.
    initial
    begin
        int held;

        receiver_held = 1'b0;
        forever
        begin
            @(receiver_hold);
            receiver_held = 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++)
                @(posedge clk);
            receiver_held = 1'b0;
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        sender_idle_pct = (mode == IDLE_SENDER) ? HEAVY_IDLE_PCT :
                          (mode == IDLE_BOTH)   ? LIGHT_IDLE_PCT : 0;
        receiver_stall_pct = (mode == IDLE_RECEIVER) ? HEAVY_IDLE_PCT :
                             (mode == IDLE_BOTH)     ? LIGHT_IDLE_PCT : 0;
    endtask

    // Send one pixel transaction, with optional idle cycles in front of it.
    task automatic send_pixel(input logic [setc_pkg::PIX_W-1:0] p);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            pix.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        pix.valid <= 1'b1;
        pix.pixel <= p;
        do @(posedge clk); while (pix.ready !== 1'b1);
        pixels_total++;
        sobel_step(p);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic wait_for_results();
        pix.valid <= 1'b0;
        while (outputs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the registers back to back; only the geometry when asked.
    task automatic program_registers(input int thr, input int fac, input int wid,
                                     input int hgt, input int emit, input bit geometry_only);
        logic [setc_pkg::CFG_IDX_W-1:0]  reg_order [5];
        logic [setc_pkg::CFG_DATA_W-1:0] value;
        int                              i;

        reg_order = '{setc_pkg::REG_THRESHOLD, setc_pkg::REG_FACTOR, setc_pkg::REG_WIDTH,
                      setc_pkg::REG_HEIGHT, setc_pkg::REG_EMIT_MAP};
        for (i = 0; i < 5; i++)
        begin
            if (geometry_only && reg_order[i] != setc_pkg::REG_WIDTH
                && reg_order[i] != setc_pkg::REG_HEIGHT)
                continue;
            case (reg_order[i])
                setc_pkg::REG_THRESHOLD:
                begin
                    value = setc_pkg::CFG_DATA_W'(thr);
                    thr_reg = value[setc_pkg::THR_W-1:0];
                end
                setc_pkg::REG_FACTOR:
                begin
                    value = setc_pkg::CFG_DATA_W'(fac);
                    factor_reg = value[setc_pkg::FAC_W-1:0];
                end
                setc_pkg::REG_WIDTH:
                begin
                    value = setc_pkg::CFG_DATA_W'(wid);
                    width_reg = value[setc_pkg::WID_W-1:0];
                end
                setc_pkg::REG_HEIGHT:
                begin
                    value = setc_pkg::CFG_DATA_W'(hgt);
                    height_reg = value[setc_pkg::ROW_W-1:0];
                end
                default:
                begin
                    value = setc_pkg::CFG_DATA_W'(emit);
                    emit_map_reg = value[0];
                end
            endcase
            cfg.valid <= 1'b1;
            cfg.index <= reg_order[i];
            cfg.data <= value;
            do @(posedge clk); while (cfg.ready !== 1'b1);
        end
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [setc_pkg::PIX_W-1:0] pattern_pixel(input pixel_pattern_t style,
                                                                 input int x, input int y);
        case (style)
            PAT_FLAT:    return setc_pkg::PIX_W'((frame_lo >> 1) + $urandom_range(0, 3));
            PAT_VSTEP:   return setc_pkg::PIX_W'((x < frame_split) ? frame_lo : frame_hi);
            PAT_HSTEP:   return setc_pkg::PIX_W'((y < frame_split) ? frame_lo : frame_hi);
            PAT_DIAG:    return setc_pkg::PIX_W'((x + y < frame_split) ? frame_lo : frame_hi);
            PAT_CHECKER: return ((x + y) % 2 == 1) ? 8'hFF : 8'h00;
            default:     return setc_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one whole frame at the configured geometry.
    task automatic send_frame(input pixel_pattern_t style);
        int w;
        int h;
        int x;
        int y;

        w = effective_width();
        h = effective_height();
        frame_lo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
        frame_hi = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255);
        frame_split = $urandom_range(0, w + h);
        for (y = 0; y < h; y++)
            for (x = 0; x < w; x++)
                send_pixel(pattern_pixel(style, x, y));
        frames_total++;
    endtask

    // Threshold, factor and map enable left at their reset values.
    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        program_registers(0, 0, 6, 5, 0, 1'b1);
        send_frame(PAT_VSTEP);
        wait_for_results();
    endtask

    // Short directed frames: largest magnitude, threshold boundary, tiny geometries.
    task automatic test_directed_cases();
        logic [setc_pkg::PIX_W-1:0] corner_edge [9];
        int                         i;

        set_idling(IDLE_NONE);
        // Window of magnitude 1530, the largest that 8-bit pixels allow.
        corner_edge = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd128, 8'd255, 8'd255};

        // Zero threshold marks the edge; density and confidence both saturate.
        program_registers(0, 65535, 3, 3, 1, 1'b0);
        for (i = 0; i < 9; i++)
            send_pixel(corner_edge[i]);
        frames_total++;
        wait_for_results();

        // A magnitude equal to the threshold is not an edge; zero factor.
        program_registers(1530, 0, 3, 3, 1, 1'b0);
        for (i = 0; i < 9; i++)
            send_pixel(corner_edge[i]);
        frames_total++;
        wait_for_results();

        // Zero width and height act as one: a single pixel ends the frame.
        program_registers(100, 256, 0, 0, 1, 1'b0);
        send_pixel(8'd255);
        frames_total++;
        wait_for_results();

        // Frames too small to have an interior report an all-zero summary.
        program_registers(0, 65535, 2, 2, 1, 1'b0);
        for (i = 0; i < 4; i++)
            send_pixel((i % 2 == 1) ? 8'd255 : 8'd0);
        frames_total++;
        wait_for_results();

        program_registers(0, 65535, 1, 3, 1, 1'b0);
        for (i = 0; i < 3; i++)
            send_pixel((i % 2 == 1) ? 8'd0 : 8'd255);
        frames_total++;
        wait_for_results();
    endtask

    // Wide and tall frames at the threshold and factor extremes.
    task automatic test_extreme_geometry();
        set_idling(IDLE_BOTH);
        program_registers(0, 65535, 100, 1, 1, 1'b0);
        send_frame(PAT_NOISE);
        wait_for_results();

        program_registers(200, 65535, 80, 3, 1, 1'b0);
        send_frame(PAT_NOISE);
        wait_for_results();

        program_registers(2047, 0, 3, 80, 1, 1'b0);
        send_frame(PAT_NOISE);
        wait_for_results();
    endtask

    // Long receiver hold while pixels keep coming, then a drain in mid-frame.
    task automatic test_backpressure();
        int w;
        int h;
        int i;

        set_idling(IDLE_NONE);
        program_registers(60, 1000, 12, 8, 1, 1'b0);
        w = effective_width();
        h = effective_height();
        frame_lo = 0;
        frame_hi = 255;
        frame_split = w / 2;
        -> receiver_hold;
        for (i = 0; i < w * h; i++)
        begin
            if (i == (w * h) / 2)
                wait_for_results();
            send_pixel(pattern_pixel(PAT_DIAG, i % w, i / w));
        end
        frames_total++;
        wait_for_results();
    endtask

    // Random configurations and frame contents, cycling through the idling modes.
    task automatic test_random_frames();
        int start_pixels;
        int frame_no;
        int thr;
        int fac;
        int wid;
        int hgt;
        int pick;

        start_pixels = pixels_total;
        frame_no = 0;
        while (pixels_total - start_pixels < RANDOM_ITEMS)
        begin
            set_idling(idle_mode_t'(frame_no % 4));

            pick = $urandom_range(0, 9);
            thr = (pick == 0) ? 0 : (pick == 1) ? 2047 :
                  (pick == 2) ? $urandom_range(0, 2047) : $urandom_range(0, 600);
            pick = $urandom_range(0, 9);
            fac = (pick == 0) ? 0 : (pick == 1) ? 65535 :
                  (pick == 2) ? $urandom_range(0, 65535) : $urandom_range(0, 600);
            wid = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
            hgt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);

            program_registers(thr, fac, wid, hgt, $urandom_range(0, 1), 1'b0);
            send_frame(pixel_pattern_t'($urandom_range(0, int'(PAT_CHECKER))));
            wait_for_results();
            frame_no++;
        end
    endtask

    // Test sequence.
    initial
    begin
        int k;

        pix.valid = 1'b0;
        pix.pixel = '0;
        cfg.valid = 1'b0;
        cfg.index = setc_pkg::REG_THRESHOLD;
        cfg.data = '0;
        rst_n = 1'b0;
        error_count = 0;
        pixels_total = 0;
        frames_total = 0;
        maps_checked = 0;
        summaries_checked = 0;
        set_idling(IDLE_NONE);

        // Shadow state at its reset values.
        thr_reg = setc_pkg::THRESHOLD_RST;
        factor_reg = setc_pkg::FACTOR_RST;
        width_reg = setc_pkg::WIDTH_RST;
        height_reg = setc_pkg::HEIGHT_RST;
        emit_map_reg = 1'b0;
        for (k = 0; k < 9; k++)
            window3x3[k / 3][k % 3] = '0;
        col_pos = 0;
        row_pos = 0;
        edge_tally = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_extreme_geometry();
        test_backpressure();
        test_random_frames();
        wait_for_results();

        $display("Covered %0d frames and %0d pixels under four idling modes,", frames_total,
                 pixels_total);
        $display("a long receiver hold and a mid-frame drain: %0d map and %0d summary results.",
                 maps_checked, summaries_checked);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
